// ===== src/mlt_pkg.sv =====
`timescale 1ns / 1ps
package mlt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int QUEUE_DEPTH   = 16;
	localparam int THREAD_BITS   = 8;

	localparam int EIDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int MADDR_W = EIDX_W + QIDX_W;

	localparam int KIND_W  = 4;
	localparam int KEY_W   = 64;
	localparam int TID_W   = 8;
	localparam int STAT_W  = 4;
	localparam int DEPTH_W = 32;
	localparam int WCNT_W  = 6;

	typedef logic [THREAD_BITS-1:0] thr_t;

	typedef enum logic [KIND_W-1:0] {
		K_ENTER   = 4'd0,
		K_EXIT    = 4'd1,
		K_WAIT    = 4'd2,
		K_RESUME  = 4'd3,
		K_NOTE1   = 4'd4,
		K_NOTEALL = 4'd5,
		K_RELEASE = 4'd6,
		K_SNAP    = 4'd7,
		K_CLEAR   = 4'd8
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 4'd0,
		STAT_ACQUIRED    = 4'd1,
		STAT_BLOCKED     = 4'd2,
		STAT_WAITING     = 4'd3,
		STAT_NOTIFIED    = 4'd4,
		STAT_TIMEOUT     = 4'd5,
		STAT_INTERRUPTED = 4'd6,
		STAT_STILL_WAIT  = 4'd7,
		STAT_BAD_ARG     = 4'd8,
		STAT_CANCELLED   = 4'd9,
		STAT_OVERFLOW    = 4'd10,
		STAT_NOT_OWNER   = 4'd11,
		STAT_NULL_REF    = 4'd12,
		STAT_TABLE_FULL  = 4'd13,
		STAT_QUEUE_FULL  = 4'd14
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_DISPATCH,
		S_W_RD,
		S_W_DAT,
		S_ENTER_Q,
		S_RES_W,
		S_RES_Q,
		S_REL_E,
		S_REL_W,
		S_REL_F,
		S_FIN
	} fsm_t;

	typedef enum logic [1:0] {
		W_FIND,
		W_NOTE1,
		W_NOTEALL,
		W_COMPACT
	} wop_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		thr_t               owner;
		logic [DEPTH_W-1:0] depth;
		logic [LEN_W-1:0]   qlen;
		logic [LEN_W-1:0]   wlen;
	} entry_t;

	typedef struct packed {
		thr_t               thr;
		logic [DEPTH_W-1:0] saved;
	} qel_t;

	typedef struct packed {
		thr_t               thr;
		logic               notified;
		logic [DEPTH_W-1:0] saved;
	} wel_t;

endpackage

// ===== src/mlt_ram.sv =====
`timescale 1ns / 1ps
module mlt_ram #(
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/reentrant_monitor_lock_table.sv =====
`timescale 1ns / 1ps
// Reentrant monitor lock table.
// Request channel: a beat is taken on a rising edge with start high and busy
// low; kind, object_id, tid, expired and interrupted are sampled then.
// Every request gives exactly one result beat: done is high for one
// cycle with status, owner_out, recursion_out and waiters_out valid.
// The receiver cannot stall; results are never held back or repeated.
// Requests decided without the table (cancelled, bad kind, null key, no
// thread, clear) answer in the cycle after the beat. Others, release_thread
// apart, scan the key table one entry a cycle until a hit or the last entry,
// then walk an entry queue or wait set in the list memories, a read state and
// a data state per element: a lookup pass, a second lookup for resume_wait, a
// marking pass for notify, and a compaction pass where an element leaves.
// release_thread visits every entry and compacts both of its lists.
// The single read port of each list memory sets the walk rate.
// Reset clears every valid bit and the cancel flag; no clearing pass runs.
module reentrant_monitor_lock_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [mlt_pkg::KIND_W-1:0] kind,
	input  logic [mlt_pkg::KEY_W-1:0]  object_id,
	input  logic [mlt_pkg::TID_W-1:0]  tid,
	input  logic                       expired,
	input  logic                       interrupted,
	output logic                       done,
	output logic [mlt_pkg::STAT_W-1:0] status,
	output logic [mlt_pkg::TID_W-1:0]  owner_out,
	output logic [mlt_pkg::DEPTH_W-1:0] recursion_out,
	output logic [mlt_pkg::WCNT_W-1:0] waiters_out
);
	import mlt_pkg::*;

	fsm_t               state_q, state_d, ret_q, ret_d;
	logic [KIND_W-1:0]  kind_q, kind_d;
	logic [KEY_W-1:0]   key_q, key_d;
	thr_t               thr_q, thr_d, t_in;
	logic               tmo_q, tmo_d, intr_q, intr_d;
	logic [EIDX_W-1:0]  e_q, e_d, free_idx_q, free_idx_d;
	logic               free_ok_q, free_ok_d, hit_q, hit_d;
	logic [LEN_W-1:0]   i_q, i_d, j_q, j_d, lst_len;
	logic               wl_q, wl_d, drop_thr_q, drop_thr_d;
	wop_t               wop_q, wop_d;
	logic [QIDX_W-1:0]  drop_idx_q, drop_idx_d, pos_q, pos_d, rw_pos_q, rw_pos_d;
	logic               found_q, found_d, fnot_q, fnot_d, rw_not_q, rw_not_d;
	logic [DEPTH_W-1:0] fsave_q, fsave_d, rw_save_q, rw_save_d;
	stat_t              stat_q, stat_d, fs;
	logic               cancel_q, cancel_d;
	logic               done_q;
	stat_t              status_q;
	thr_t               own_q, sn_own;
	logic [DEPTH_W-1:0] rec_q, sn_rec;
	logic [WCNT_W-1:0]  wcnt_q, sn_w;
	logic               fire;

	logic               valid_q [TABLE_ENTRIES];
	entry_t             ent_q [TABLE_ENTRIES];
	entry_t             cur, ent_nx;
	logic               ent_we, val_set, val_clr, val_clr_all, drop;

	logic [MADDR_W-1:0] raddr, qwa, wwa;
	logic               qwe, wwe;
	qel_t               qwd, q_rd;
	wel_t               wwd, w_rd;
	thr_t               rthr;
	logic [DEPTH_W-1:0] nd;

	mlt_ram #(.WIDTH($bits(qel_t)), .AW(MADDR_W)) u_qram (
		.clk(clk), .we(qwe), .waddr(qwa), .wdata(qwd), .raddr(raddr), .rdata(q_rd)
	);

	mlt_ram #(.WIDTH($bits(wel_t)), .AW(MADDR_W)) u_wram (
		.clk(clk), .we(wwe), .waddr(wwa), .wdata(wwd), .raddr(raddr), .rdata(w_rd)
	);

	assign t_in    = tid[THREAD_BITS-1:0];
	assign cur     = ent_q[e_q];
	assign lst_len = wl_q ? cur.wlen : cur.qlen;
	assign rthr    = wl_q ? w_rd.thr : q_rd.thr;
	assign raddr   = {e_q, i_q[QIDX_W-1:0]};
	assign nd      = cur.depth - DEPTH_W'(1);
	assign busy    = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q; ret_d = ret_q; kind_d = kind_q; key_d = key_q;
		thr_d = thr_q; tmo_d = tmo_q; intr_d = intr_q; e_d = e_q;
		free_idx_d = free_idx_q; free_ok_d = free_ok_q; hit_d = hit_q;
		i_d = i_q; j_d = j_q; wl_d = wl_q; drop_thr_d = drop_thr_q; wop_d = wop_q;
		drop_idx_d = drop_idx_q; pos_d = pos_q; rw_pos_d = rw_pos_q;
		found_d = found_q; fnot_d = fnot_q; rw_not_d = rw_not_q;
		fsave_d = fsave_q; rw_save_d = rw_save_q; stat_d = stat_q; cancel_d = cancel_q;
		fire = 1'b0; fs = STAT_OK; sn_own = '0; sn_rec = '0; sn_w = '0;
		ent_nx = cur; ent_we = 1'b0; val_set = 1'b0; val_clr = 1'b0; val_clr_all = 1'b0;
		qwe = 1'b0; qwa = {e_q, i_q[QIDX_W-1:0]}; qwd = q_rd;
		wwe = 1'b0; wwa = {e_q, i_q[QIDX_W-1:0]}; wwd = w_rd;
		drop = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_d = kind; key_d = object_id; thr_d = t_in;
					tmo_d = expired; intr_d = interrupted;
					e_d = '0; hit_d = 1'b0; free_ok_d = 1'b0;
					if (cancel_q) begin
						fire = 1'b1; fs = STAT_CANCELLED;
					end else if (kind > KIND_W'(K_CLEAR)) begin
						fire = 1'b1; fs = STAT_BAD_ARG;
					end else if (kind == KIND_W'(K_CLEAR)) begin
						cancel_d = 1'b1; val_clr_all = 1'b1; fire = 1'b1; fs = STAT_OK;
					end else if (kind == KIND_W'(K_SNAP)) begin
						if (object_id == '0) begin
							fire = 1'b1; fs = STAT_BAD_ARG;
						end else begin
							state_d = S_SEARCH;
						end
					end else if (kind == KIND_W'(K_RELEASE)) begin
						if (t_in == '0) begin
							fire = 1'b1; fs = STAT_BAD_ARG;
						end else begin
							state_d = S_REL_E;
						end
					end else if (object_id == '0) begin
						fire = 1'b1;
						fs = (kind <= KIND_W'(K_EXIT)) ? STAT_BAD_ARG : STAT_NULL_REF;
					end else if (t_in == '0) begin
						fire = 1'b1; fs = STAT_BAD_ARG;
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				if (valid_q[e_q] && cur.key == key_q) begin
					hit_d = 1'b1; state_d = S_DISPATCH;
				end else begin
					if (!valid_q[e_q] && !free_ok_q) begin
						free_ok_d = 1'b1; free_idx_d = e_q;
					end
					if (e_q == EIDX_W'(TABLE_ENTRIES - 1)) begin
						state_d = S_DISPATCH;
						e_d = free_ok_q ? free_idx_q : e_q;
					end else begin
						e_d = e_q + EIDX_W'(1);
					end
				end
			end
			S_DISPATCH: begin
				case (kind_q)
					KIND_W'(K_SNAP): begin
						fire = 1'b1; fs = STAT_OK;
						if (hit_q) begin
							sn_own = cur.owner; sn_rec = cur.depth;
							sn_w = WCNT_W'(cur.qlen) + WCNT_W'(cur.wlen);
						end
					end
					KIND_W'(K_ENTER): begin
						if (!hit_q) begin
							fire = 1'b1;
							if (!free_ok_q) begin
								fs = STAT_TABLE_FULL;
							end else begin
								val_set = 1'b1; ent_we = 1'b1; fs = STAT_ACQUIRED;
								ent_nx = '{key: key_q, owner: thr_q, depth: DEPTH_W'(1),
									qlen: '0, wlen: '0};
							end
						end else if (cur.owner == '0 && cur.qlen == '0) begin
							ent_nx.owner = thr_q; ent_nx.depth = DEPTH_W'(1); ent_we = 1'b1;
							fire = 1'b1; fs = STAT_ACQUIRED;
						end else if (cur.owner == thr_q) begin
							fire = 1'b1;
							if (&cur.depth) begin
								fs = STAT_OVERFLOW;
							end else begin
								ent_nx.depth = cur.depth + DEPTH_W'(1); ent_we = 1'b1;
								fs = STAT_ACQUIRED;
							end
						end else begin
							i_d = '0; j_d = '0; found_d = 1'b0; wl_d = 1'b0; wop_d = W_FIND;
							ret_d = S_ENTER_Q; state_d = S_W_RD;
						end
					end
					default: begin
						if (!hit_q) begin
							fire = 1'b1;
							fs = (kind_q == KIND_W'(K_RESUME)) ? STAT_BAD_ARG : STAT_NOT_OWNER;
						end else if (kind_q == KIND_W'(K_RESUME)) begin
							i_d = '0; j_d = '0; found_d = 1'b0; wl_d = 1'b1; wop_d = W_FIND;
							ret_d = S_RES_W; state_d = S_W_RD;
						end else if (cur.owner != thr_q ||
							((kind_q == KIND_W'(K_EXIT) || kind_q == KIND_W'(K_WAIT)) &&
							cur.depth == '0)) begin
							fire = 1'b1; fs = STAT_NOT_OWNER;
						end else if (kind_q == KIND_W'(K_EXIT)) begin
							ent_nx.depth = nd; ent_we = 1'b1; fire = 1'b1; fs = STAT_OK;
							if (nd == '0) begin
								ent_nx.owner = '0;
								if (cur.qlen == '0 && cur.wlen == '0) begin
									val_clr = 1'b1;
								end
							end
						end else if (kind_q == KIND_W'(K_WAIT)) begin
							fire = 1'b1;
							if (cur.wlen >= LEN_W'(QUEUE_DEPTH)) begin
								fs = STAT_QUEUE_FULL;
							end else begin
								wwe = 1'b1; wwa = {e_q, cur.wlen[QIDX_W-1:0]};
								wwd = '{thr: thr_q, notified: 1'b0, saved: cur.depth};
								ent_nx.wlen = cur.wlen + LEN_W'(1);
								ent_nx.owner = '0; ent_nx.depth = '0; ent_we = 1'b1;
								fs = STAT_WAITING;
							end
						end else begin
							i_d = '0; j_d = '0; wl_d = 1'b1; stat_d = STAT_OK;
							wop_d = (kind_q == KIND_W'(K_NOTE1)) ? W_NOTE1 : W_NOTEALL;
							ret_d = S_FIN; state_d = S_W_RD;
						end
					end
				endcase
			end
			S_W_RD: begin
				if (i_q == lst_len) begin
					if (wop_q == W_COMPACT) begin
						ent_we = 1'b1;
						if (wl_q) begin
							ent_nx.wlen = j_q;
						end else begin
							ent_nx.qlen = j_q;
						end
					end
					state_d = ret_q;
				end else begin
					state_d = S_W_DAT;
				end
			end
			S_W_DAT: begin
				state_d = S_W_RD; i_d = i_q + LEN_W'(1);
				case (wop_q)
					W_FIND: begin
						if (rthr == thr_q) begin
							found_d = 1'b1; pos_d = i_q[QIDX_W-1:0]; fnot_d = w_rd.notified;
							fsave_d = wl_q ? w_rd.saved : q_rd.saved;
							state_d = ret_q;
						end
					end
					W_NOTE1: begin
						if (!w_rd.notified) begin
							wwe = 1'b1; wwd.notified = 1'b1; state_d = ret_q;
						end
					end
					W_NOTEALL: begin
						wwe = 1'b1; wwd.notified = 1'b1;
					end
					default: begin
						drop = drop_thr_q ? (rthr == thr_q) : (i_q[QIDX_W-1:0] == drop_idx_q);
						if (!drop) begin
							j_d = j_q + LEN_W'(1);
							if (wl_q) begin
								wwe = 1'b1; wwa = {e_q, j_q[QIDX_W-1:0]};
							end else begin
								qwe = 1'b1; qwa = {e_q, j_q[QIDX_W-1:0]};
							end
						end
					end
				endcase
			end
			S_ENTER_Q: begin
				if (found_q && pos_q == '0 && cur.owner == '0) begin
					ent_nx.owner = thr_q; ent_nx.depth = fsave_q; ent_we = 1'b1;
					i_d = '0; j_d = '0; wl_d = 1'b0; wop_d = W_COMPACT;
					drop_thr_d = 1'b0; drop_idx_d = '0;
					stat_d = STAT_ACQUIRED; ret_d = S_FIN; state_d = S_W_RD;
				end else if (found_q) begin
					fire = 1'b1; fs = STAT_BLOCKED;
				end else if (cur.qlen >= LEN_W'(QUEUE_DEPTH)) begin
					fire = 1'b1; fs = STAT_QUEUE_FULL;
				end else begin
					qwe = 1'b1; qwa = {e_q, cur.qlen[QIDX_W-1:0]};
					qwd = '{thr: thr_q, saved: DEPTH_W'(1)};
					ent_nx.qlen = cur.qlen + LEN_W'(1); ent_we = 1'b1;
					fire = 1'b1; fs = STAT_BLOCKED;
				end
			end
			S_RES_W: begin
				if (!found_q) begin
					fire = 1'b1; fs = STAT_BAD_ARG;
				end else if (!fnot_q && !tmo_q && !intr_q) begin
					fire = 1'b1; fs = STAT_STILL_WAIT;
				end else begin
					rw_pos_d = pos_q; rw_not_d = fnot_q; rw_save_d = fsave_q;
					i_d = '0; j_d = '0; found_d = 1'b0; wl_d = 1'b0; wop_d = W_FIND;
					ret_d = S_RES_Q; state_d = S_W_RD;
				end
			end
			S_RES_Q: begin
				if (!found_q && cur.qlen >= LEN_W'(QUEUE_DEPTH)) begin
					fire = 1'b1; fs = STAT_QUEUE_FULL;
				end else begin
					qwe = 1'b1; qwd = '{thr: thr_q, saved: rw_save_q};
					if (found_q) begin
						qwa = {e_q, pos_q};
					end else begin
						qwa = {e_q, cur.qlen[QIDX_W-1:0]};
						ent_nx.qlen = cur.qlen + LEN_W'(1); ent_we = 1'b1;
					end
					i_d = '0; j_d = '0; wl_d = 1'b1; wop_d = W_COMPACT;
					drop_thr_d = 1'b0; drop_idx_d = rw_pos_q;
					stat_d = intr_q ? STAT_INTERRUPTED :
						(rw_not_q ? STAT_NOTIFIED : STAT_TIMEOUT);
					ret_d = S_FIN; state_d = S_W_RD;
				end
			end
			S_REL_E: begin
				if (valid_q[e_q]) begin
					if (cur.owner == thr_q) begin
						ent_nx.owner = '0; ent_nx.depth = '0; ent_we = 1'b1;
					end
					i_d = '0; j_d = '0; wl_d = 1'b0; wop_d = W_COMPACT; drop_thr_d = 1'b1;
					ret_d = S_REL_W; state_d = S_W_RD;
				end else begin
					state_d = S_REL_F;
				end
			end
			S_REL_W: begin
				i_d = '0; j_d = '0; wl_d = 1'b1; wop_d = W_COMPACT; drop_thr_d = 1'b1;
				ret_d = S_REL_F; state_d = S_W_RD;
			end
			S_REL_F: begin
				if (valid_q[e_q] && cur.owner == '0 && cur.qlen == '0 && cur.wlen == '0) begin
					val_clr = 1'b1;
				end
				if (e_q == EIDX_W'(TABLE_ENTRIES - 1)) begin
					fire = 1'b1; fs = STAT_OK;
				end else begin
					e_d = e_q + EIDX_W'(1); state_d = S_REL_E;
				end
			end
			S_FIN: begin
				fire = 1'b1; fs = stat_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fire) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cancel_q <= 1'b0;
			done_q   <= 1'b0;
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else begin
			state_q  <= state_d;
			cancel_q <= cancel_d;
			done_q   <= fire;
			if (val_clr_all) begin
				for (int k = 0; k < TABLE_ENTRIES; k++) begin
					valid_q[k] <= 1'b0;
				end
			end else if (val_set) begin
				valid_q[e_q] <= 1'b1;
			end else if (val_clr) begin
				valid_q[e_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ret_q <= ret_d; kind_q <= kind_d; key_q <= key_d; thr_q <= thr_d;
		tmo_q <= tmo_d; intr_q <= intr_d; e_q <= e_d; free_idx_q <= free_idx_d;
		free_ok_q <= free_ok_d; hit_q <= hit_d; i_q <= i_d; j_q <= j_d; wl_q <= wl_d;
		drop_thr_q <= drop_thr_d; wop_q <= wop_d; drop_idx_q <= drop_idx_d;
		pos_q <= pos_d; rw_pos_q <= rw_pos_d; found_q <= found_d; fnot_q <= fnot_d;
		rw_not_q <= rw_not_d; fsave_q <= fsave_d; rw_save_q <= rw_save_d; stat_q <= stat_d;
		if (ent_we) begin
			ent_q[e_q] <= ent_nx;
		end
		if (fire) begin
			status_q <= fs; own_q <= sn_own; rec_q <= sn_rec; wcnt_q <= sn_w;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign owner_out     = TID_W'(own_q);
	assign recursion_out = rec_q;
	assign waiters_out   = wcnt_q;

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted beat neither busy nor answered");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_cancel_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cancel_q |=> cancel_q)
		else $error("cancel flag dropped");

	a_cancel_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cancel_q) |-> status == STAT_W'(STAT_CANCELLED) || !$past(start))
		else $error("request after clear not cancelled");

endmodule

// ===== dv/reentrant_monitor_lock_table_test.sv =====
`timescale 1ns / 1ps
module reentrant_monitor_lock_table_test;
	import mlt_pkg::*;

	localparam int NE = TABLE_ENTRIES;
	localparam int QD = QUEUE_DEPTH;

	typedef struct {
		logic [3:0]  st;
		logic [7:0]  own;
		logic [31:0] rec;
		logic [5:0]  wcnt;
	} lock_reply_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic [3:0] kind = '0;
	logic [63:0] object_id = '0;
	logic [7:0] tid = '0;
	logic expired = 0, interrupted = 0;
	logic [3:0] status;
	logic [7:0] owner_out;
	logic [31:0] recursion_out;
	logic [5:0] waiters_out;

	reentrant_monitor_lock_table u_top (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// shadow lock table
	bit          slot_used [NE];
	logic [63:0] slot_key [NE];
	logic [7:0]  slot_owner [NE];
	logic [31:0] slot_depth [NE];
	logic [7:0]  entq_thr [NE][$];
	logic [31:0] entq_cnt [NE][$];
	logic [7:0]  ws_thr [NE][$];
	bit          ws_note [NE][$];
	logic [31:0] ws_cnt [NE][$];
	bit          table_dead;

	lock_reply_t pending_replies[$];
	int errors = 0;
	int beats_sent = 0;
	int replies_seen = 0;
	int stat_hist [16];

	function automatic int find_slot(logic [63:0] key);
		for (int e = 0; e < NE; e++)
			if (slot_used[e] && slot_key[e] == key)
				return e;
		return -1;
	endfunction

	function automatic int entq_find(int e, logic [7:0] t);
		foreach (entq_thr[e][i])
			if (entq_thr[e][i] == t)
				return i;
		return -1;
	endfunction

	function automatic int ws_find(int e, logic [7:0] t);
		foreach (ws_thr[e][i])
			if (ws_thr[e][i] == t)
				return i;
		return -1;
	endfunction

	function automatic void drop_if_idle(int e);
		if (slot_owner[e] == 0 && entq_thr[e].size() == 0 && ws_thr[e].size() == 0)
			slot_used[e] = 0;
	endfunction

	function automatic stat_t lock_enter(logic [63:0] key, logic [7:0] t);
		int e;
		logic [31:0] d;
		e = find_slot(key);
		if (e < 0) begin
			for (int i = 0; i < NE; i++)
				if (!slot_used[i]) begin
					e = i;
					break;
				end
			if (e < 0)
				return STAT_TABLE_FULL;
			slot_used[e] = 1;
			slot_key[e] = key;
			slot_owner[e] = 0;
			slot_depth[e] = 0;
			entq_thr[e].delete();
			entq_cnt[e].delete();
			ws_thr[e].delete();
			ws_note[e].delete();
			ws_cnt[e].delete();
		end
		if (slot_owner[e] == 0 && (entq_thr[e].size() == 0 || entq_thr[e][0] == t)) begin
			d = 1;
			if (entq_thr[e].size() != 0) begin
				d = entq_cnt[e][0];
				entq_cnt[e].delete(0);
				entq_thr[e].delete(0);
			end
			slot_owner[e] = t;
			slot_depth[e] = d;
			return STAT_ACQUIRED;
		end
		if (slot_owner[e] == t) begin
			if (slot_depth[e] == 32'hFFFF_FFFF)
				return STAT_OVERFLOW;
			slot_depth[e]++;
			return STAT_ACQUIRED;
		end
		if (entq_find(e, t) >= 0)
			return STAT_BLOCKED;
		if (entq_thr[e].size() >= QD)
			return STAT_QUEUE_FULL;
		entq_thr[e].insert(entq_thr[e].size(), t);
		entq_cnt[e].insert(entq_cnt[e].size(), 1);
		return STAT_BLOCKED;
	endfunction

	function automatic stat_t lock_resume(int e, logic [7:0] t, bit tmo, bit intr);
		int w, q;
		bit nt;
		w = ws_find(e, t);
		if (w < 0)
			return STAT_BAD_ARG;
		nt = ws_note[e][w];
		if (!nt && !tmo && !intr)
			return STAT_STILL_WAIT;
		q = entq_find(e, t);
		if (q >= 0)
			entq_cnt[e][q] = ws_cnt[e][w];
		else begin
			if (entq_thr[e].size() >= QD)
				return STAT_QUEUE_FULL;
			entq_thr[e].insert(entq_thr[e].size(), t);
			entq_cnt[e].insert(entq_cnt[e].size(), ws_cnt[e][w]);
		end
		ws_thr[e].delete(w);
		ws_note[e].delete(w);
		ws_cnt[e].delete(w);
		if (intr)
			return STAT_INTERRUPTED;
		return nt ? STAT_NOTIFIED : STAT_TIMEOUT;
	endfunction

	function automatic lock_reply_t predict_lock(logic [3:0] k, logic [63:0] key,
			logic [7:0] t, bit tmo, bit intr);
		lock_reply_t r;
		int e, p, n;
		r = '{STAT_OK, 0, 0, 0};
		e = find_slot(key);
		if (table_dead)
			r.st = STAT_CANCELLED;
		else if (k > K_CLEAR)
			r.st = STAT_BAD_ARG;
		else if (k == K_CLEAR) begin
			table_dead = 1;
			foreach (slot_used[i])
				slot_used[i] = 0;
		end else if (k == K_SNAP) begin
			if (key == 0)
				r.st = STAT_BAD_ARG;
			else begin
				if (e >= 0) begin
					n = entq_thr[e].size() + ws_thr[e].size();
					r.own = slot_owner[e];
					r.rec = slot_depth[e];
					r.wcnt = n > 63 ? 63 : n;
				end
			end
		end else if (k == K_RELEASE) begin
			if (t == 0)
				r.st = STAT_BAD_ARG;
			else
				for (int i = 0; i < NE; i++) begin
					if (!slot_used[i])
						continue;
					if (slot_owner[i] == t) begin
						slot_owner[i] = 0;
						slot_depth[i] = 0;
					end
					p = entq_find(i, t);
					while (p >= 0) begin
						entq_thr[i].delete(p);
						entq_cnt[i].delete(p);
						p = entq_find(i, t);
					end
					p = ws_find(i, t);
					while (p >= 0) begin
						ws_thr[i].delete(p);
						ws_note[i].delete(p);
						ws_cnt[i].delete(p);
						p = ws_find(i, t);
					end
					drop_if_idle(i);
				end
		end else if (key == 0)
			r.st = (k <= K_EXIT) ? STAT_BAD_ARG : STAT_NULL_REF;
		else if (t == 0)
			r.st = STAT_BAD_ARG;
		else if (k == K_ENTER)
			r.st = lock_enter(key, t);
		else if (e < 0)
			r.st = (k == K_RESUME) ? STAT_BAD_ARG : STAT_NOT_OWNER;
		else if (k == K_RESUME)
			r.st = lock_resume(e, t, tmo, intr);
		else if (slot_owner[e] != t || ((k == K_EXIT || k == K_WAIT) && slot_depth[e] == 0))
			r.st = STAT_NOT_OWNER;
		else if (k == K_EXIT) begin
			slot_depth[e]--;
			if (slot_depth[e] == 0) begin
				slot_owner[e] = 0;
				drop_if_idle(e);
			end
		end else if (k == K_WAIT) begin
			if (ws_thr[e].size() >= QD)
				r.st = STAT_QUEUE_FULL;
			else begin
				ws_thr[e].insert(ws_thr[e].size(), t);
				ws_note[e].insert(ws_note[e].size(), 0);
				ws_cnt[e].insert(ws_cnt[e].size(), slot_depth[e]);
				slot_owner[e] = 0;
				slot_depth[e] = 0;
				r.st = STAT_WAITING;
			end
		end else if (k == K_NOTE1) begin
			foreach (ws_note[e][i])
				if (!ws_note[e][i]) begin
					ws_note[e][i] = 1;
					break;
				end
		end else
			foreach (ws_note[e][i])
				ws_note[e][i] = 1;
		return r;
	endfunction

	// sender burst/gap pacing
	int burst_left = 0;

	task automatic send_req(logic [3:0] k, logic [63:0] key, logic [7:0] t,
			bit tmo = 0, bit intr = 0);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				start <= 0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1;
		kind <= k;
		object_id <= key;
		tid <= t;
		expired <= tmo;
		interrupted <= intr;
		do
			@(posedge clk);
		while (busy);
		pending_replies.insert(pending_replies.size(), predict_lock(k, key, t, tmo, intr));
		beats_sent++;
	endtask

	task automatic drain();
		start <= 0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		lock_reply_t x;
		if (arst_n && done) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat status %0d", $time, status);
			end else begin
				x = pending_replies[0];
				pending_replies.delete(0);
				stat_hist[x.st]++;
				if (status !== x.st || owner_out !== x.own || recursion_out !== x.rec
						|| waiters_out !== x.wcnt) begin
					errors++;
					$display("%0t: expected st %0d own %0d rec %0d wait %0d, got %0d %0d %0d %0d",
						$time, x.st, x.own, x.rec, x.wcnt,
						status, owner_out, recursion_out, waiters_out);
				end
			end
		end
	end

	logic [63:0] keys [6] = '{64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_0000_1234_5678,
		64'h8000_0000_0000_0000, 64'h7, 64'h5A5A_FFFF_0000_0001};

	function automatic logic [7:0] rnd_thr();
		return ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
	endfunction

	task automatic test_directed();
		send_req(K_SNAP, 0, 0);
		send_req(4'd9, 64'h1, 1);
		send_req(4'd15, 64'h1, 1);
		send_req(K_ENTER, 0, 1);
		send_req(K_EXIT, 0, 1);
		send_req(K_WAIT, 0, 1);
		send_req(K_NOTE1, 0, 1);
		send_req(K_ENTER, keys[1], 0);
		send_req(K_RELEASE, 0, 0);
		send_req(K_EXIT, keys[1], 8'hFF);
		send_req(K_RESUME, keys[1], 8'hFF);
		send_req(K_ENTER, keys[1], 8'hFF);
		send_req(K_ENTER, keys[1], 8'hFF);
		send_req(K_ENTER, keys[1], 8'h01);
		send_req(K_WAIT, keys[1], 8'hFF);
		send_req(K_RESUME, keys[1], 8'hFF);
		send_req(K_NOTEALL, keys[1], 8'h01);
		send_req(K_SNAP, keys[1], 0);
		send_req(K_ENTER, keys[1], 8'h01);
		send_req(K_NOTE1, keys[1], 8'h01);
		send_req(K_RESUME, keys[1], 8'hFF, 1, 1);
		send_req(K_EXIT, keys[1], 8'h01);
		send_req(K_ENTER, keys[1], 8'hFF);
		send_req(K_SNAP, keys[1], 0);
		send_req(K_RELEASE, 0, 8'hFF);
	endtask

	task automatic test_full_table_and_queue();
		for (int i = 1; i <= NE + 1; i++)
			send_req(K_ENTER, 64'h100 + i, 8'd1);
		for (int t = 2; t <= QD + 2; t++)
			send_req(K_ENTER, 64'h101, 8'(t));
		send_req(K_SNAP, 64'h101, 0);
		drain();
		for (int t = 1; t <= QD + 2; t++)
			send_req(K_RELEASE, 0, 8'(t));
	endtask

	task automatic test_wait_set_full();
		for (int t = 1; t <= QD + 1; t++) begin
			send_req(K_ENTER, 64'h55, 8'(t));
			send_req(K_WAIT, 64'h55, 8'(t));
		end
		send_req(K_NOTE1, 64'h55, 8'd1);
		send_req(K_ENTER, 64'h55, 8'd40);
		send_req(K_NOTEALL, 64'h55, 8'd40);
		for (int t = 1; t <= QD; t++)
			send_req(K_RESUME, 64'h55, 8'(t), $urandom_range(0, 1), $urandom_range(0, 1));
		send_req(K_SNAP, 64'h55, 0);
		for (int t = 1; t <= QD + 1; t++)
			send_req(K_RELEASE, 0, 8'(t));
		send_req(K_RELEASE, 0, 8'd40);
	endtask

	// random mix: enter/exit/wait/resume/notify/release/snap and bad kinds
	task automatic test_random_traffic(int n);
		logic [63:0] key;
		logic [7:0] t;
		int r;
		for (int i = 0; i < n; i++) begin
			key = ($urandom_range(0, 29) == 0) ? 0 :
				($urandom_range(0, 39) == 0) ? {$urandom, $urandom} : keys[$urandom_range(0, 5)];
			t = rnd_thr();
			r = $urandom_range(0, 99);
			if (r < 30)
				send_req(K_ENTER, key, t);
			else if (r < 45)
				send_req(K_EXIT, key, t);
			else if (r < 55)
				send_req(K_WAIT, key, t);
			else if (r < 68)
				send_req(K_RESUME, key, t, $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
			else if (r < 76)
				send_req(K_NOTE1, key, t);
			else if (r < 81)
				send_req(K_NOTEALL, key, t);
			else if (r < 85)
				send_req(K_RELEASE, key, t);
			else if (r < 97)
				send_req(K_SNAP, key, t);
			else
				send_req(4'($urandom_range(9, 15)), key, t);
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	task automatic test_clear();
		send_req(K_CLEAR, 0, 0);
		send_req(K_SNAP, keys[0], 0);
		send_req(K_CLEAR, keys[1], 8'hFF);
		send_req(K_ENTER, keys[2], 1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_full_table_and_queue();
		test_wait_set_full();
		test_random_traffic(560);
		test_clear();
		drain();
		repeat (100) @(posedge clk);
		$display("Sent %0d requests, %0d results; acquired %0d, blocked %0d, waiting %0d,",
			beats_sent, replies_seen, stat_hist[STAT_ACQUIRED], stat_hist[STAT_BLOCKED],
			stat_hist[STAT_WAITING]);
		$display("notified %0d, queue_full %0d, table_full %0d, cancelled %0d.",
			stat_hist[STAT_NOTIFIED], stat_hist[STAT_QUEUE_FULL], stat_hist[STAT_TABLE_FULL],
			stat_hist[STAT_CANCELLED]);
		if (errors == 0 && pending_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
